FILE: rtl/core/coo_pkg.sv
package coo_pkg;

	// Phase accumulator and cosine table geometry
	localparam int PHASE_BITS        = 24;
	localparam int COS_TABLE_ENTRIES = 1024;
	localparam int CIDX_W            = $clog2(COS_TABLE_ENTRIES);
	localparam int COEF_W            = 17;

	// Field widths
	localparam int TIME_W     = 32;
	localparam int PCT_W      = 7;
	localparam int BASE_W     = 16;
	localparam int SPD_W      = 16;
	localparam int AMP_W      = 16;
	localparam int PER_W      = 24;
	localparam int OFS_W      = 17;
	localparam int FRAC_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Shared multiplier
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 24;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Divide by 100 through a reciprocal: exact for inputs below 2^23
	localparam int                 RECIP_IN_W  = 23;
	localparam int                 RECIP_SHIFT = 30;
	localparam logic [MUL_B_W-1:0] RECIP_100   = 24'd10737419;

	// Shared divider, two quotient bits per cycle
	localparam int DIV_NW    = ((BASE_W + PHASE_BITS + 1) / 2) * 2;
	localparam int DIV_DW    = 34;
	localparam int DIV_ITER  = DIV_NW / 2;
	localparam int DIV_CNT_W = $clog2(DIV_ITER);
	localparam int PMIN_W    = 24;

	// Scalars
	localparam int unsigned GAP_LIMIT_MS = 1000;
	localparam int unsigned PCT_FULL     = 100;
	localparam int unsigned PMIN_SCALE   = 200;
	localparam int unsigned MS_TO_US     = 1000;
	localparam int unsigned LOOP_RESET   = 2500;
	localparam int unsigned MAG_ROUND    = 32768;
	localparam int          MAG_SHIFT    = 16;
	localparam int          MAG_SUM_W    = COEF_W + AMP_W + 1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMP_BASE  = 3'd0,
		REG_PER_BASE  = 3'd1,
		REG_LOOP      = 3'd2,
		REG_AMP_KNOB  = 3'd3,
		REG_PER_KNOB  = 3'd4
	} cfg_reg_t;

	// Micro-operations of the datapath
	typedef enum logic [3:0] {
		U_FETCH,
		U_NOP,
		U_GAP,
		U_MUL_AMP,
		U_RECIP,
		U_AMP_MUL_PER,
		U_PER_MUL_200,
		U_DIV_PMIN,
		U_MAX_PMIN,
		U_MUL_1000,
		U_DIV_STEP,
		U_ADD_STEP,
		U_AMP_ZERO,
		U_MUL_MAG,
		U_EMIT
	} uop_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_DROP,
		C_SPD_ZERO,
		C_NO_ADV,
		C_DIV_BUSY,
		C_OUT_FULL
	} cond_sel_t;

	localparam int UC_DEPTH = 18;
	localparam int UC_PC_W  = $clog2(UC_DEPTH);

	typedef struct packed {
		uop_t               op;
		cond_sel_t          cond;
		logic [UC_PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic no_in;
		logic drop;
		logic spd_zero;
		logic no_adv;
		logic div_busy;
		logic out_full;
	} uflags_t;

	// Cosine table, stored as 32768 - cos in Q15
	typedef logic [COEF_W-1:0] coef_rom_t [COS_TABLE_ENTRIES];

	localparam longint Q30_ONE      = 64'sd1 << 30;
	localparam longint HALF_PI_Q30  = 64'sd1686629713;
	localparam longint Q15_ROUND    = 64'sd1 << 14;
	localparam longint COS_ONE_Q15  = 64'sd32768;
	localparam longint TAYLOR_DEN_0 = 132 * Q30_ONE;
	localparam longint TAYLOR_DEN_1 = 90 * Q30_ONE;
	localparam longint TAYLOR_DEN_2 = 56 * Q30_ONE;
	localparam longint TAYLOR_DEN_3 = 30 * Q30_ONE;
	localparam longint TAYLOR_DEN_4 = 12 * Q30_ONE;
	localparam longint TAYLOR_DEN_5 = 2 * Q30_ONE;

	function automatic logic [PCT_W-1:0] sat_pct(logic [PCT_W-1:0] p);
		return (p > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : p;
	endfunction

	// cos(pi/2 * num / entries) in Q30 by nested Taylor series, clamped to [0, 1]
	function automatic longint cos_quarter_q30(longint num);
		longint x;
		longint x2;
		longint t;
		x  = (HALF_PI_Q30 * num) / COS_TABLE_ENTRIES;
		x2 = (x * x) >>> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - (x2 * t) / TAYLOR_DEN_0;
		t  = Q30_ONE - (x2 * t) / TAYLOR_DEN_1;
		t  = Q30_ONE - (x2 * t) / TAYLOR_DEN_2;
		t  = Q30_ONE - (x2 * t) / TAYLOR_DEN_3;
		t  = Q30_ONE - (x2 * t) / TAYLOR_DEN_4;
		t  = Q30_ONE - (x2 * t) / TAYLOR_DEN_5;
		if (t < 0)
			t = 0;
		if (t > Q30_ONE)
			t = Q30_ONE;
		return t;
	endfunction

	function automatic coef_rom_t build_coef_rom();
		coef_rom_t rom;
		longint    q;
		longint    r;
		longint    v;
		longint    c;
		logic      neg;
		for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
			q = (4 * longint'(k)) / COS_TABLE_ENTRIES;
			r = (4 * longint'(k)) % COS_TABLE_ENTRIES;
			if (q == 0) begin
				v   = cos_quarter_q30(r);
				neg = 1'b0;
			end else if (q == 1) begin
				v   = cos_quarter_q30(COS_TABLE_ENTRIES - r);
				neg = 1'b1;
			end else if (q == 2) begin
				v   = cos_quarter_q30(r);
				neg = 1'b1;
			end else begin
				v   = cos_quarter_q30(COS_TABLE_ENTRIES - r);
				neg = 1'b0;
			end
			v      = (v + Q15_ROUND) >>> 15;
			c      = neg ? -v : v;
			rom[k] = COEF_W'(COS_ONE_Q15 - c);
		end
		return rom;
	endfunction

endpackage

FILE: rtl/core/cosine_offset_oscillator_top.sv
// Each accepted word runs through the microprogram to its result; the minimum-period divide
// is skipped when the speed limit is zero, the step divide when the phase does not advance.
// Words do not overlap: a new one is taken only at the fetch step, after the last is emitted;
// up to two passes use the shared two-bit-per-cycle divider; dropped words return to fetch.
// Reset clears phase and last tick time and loads the register defaults; the cosine
// table is a constant ROM and needs no fill.
module cosine_offset_oscillator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [coo_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [coo_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                active,
	input  logic [coo_pkg::TIME_W-1:0]          now_ms,
	input  logic [coo_pkg::PCT_W-1:0]           amplitude_pct,
	input  logic [coo_pkg::PCT_W-1:0]           period_pct,
	input  logic [coo_pkg::SPD_W-1:0]           max_climb_cms,
	input  logic [coo_pkg::SPD_W-1:0]           max_descent_cms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [coo_pkg::OFS_W-1:0]    offset_mm,
	output logic [coo_pkg::FRAC_W-1:0]          phase_frac
);
	import coo_pkg::*;

	localparam coef_rom_t COEF_ROM = build_coef_rom();
	localparam int        IDXP_W   = PHASE_BITS + CIDX_W + 1;

	// Configuration
	logic [BASE_W-1:0] amp_base_q;
	logic [BASE_W-1:0] per_base_q;
	logic [BASE_W-1:0] loop_q;
	logic              amp_knob_q;
	logic              per_knob_q;

	// Latched input word
	logic              act_q;
	logic [TIME_W-1:0] now_q;
	logic [PCT_W-1:0]  apct_q;
	logic [PCT_W-1:0]  ppct_q;
	logic [SPD_W-1:0]  climb_q;
	logic [SPD_W-1:0]  desc_q;

	// Datapath
	logic [PHASE_BITS-1:0] phase_q;
	logic [TIME_W-1:0]     last_q;
	logic [TIME_W-1:0]     gap_ms;
	logic [AMP_W-1:0]      amp_q;
	logic [PER_W-1:0]      per_q;
	logic [SPD_W-1:0]      spd_q;
	logic                  stop_q;
	logic [PROD_W-1:0]     prod_q;
	logic [MUL_A_W-1:0]    mul_a;
	logic [MUL_B_W-1:0]    mul_b;
	logic [PROD_W-1:0]     mul_p;
	logic                  mul_en;
	logic [PCT_W-1:0]      pct_a;
	logic [PCT_W-1:0]      pct_p;
	logic [COEF_W-1:0]     coef_q;
	logic [IDXP_W-1:0]     idx_prod;
	logic [CIDX_W-1:0]     cidx;
	logic [MAG_SUM_W-1:0]  mag_sum;
	logic [OFS_W-1:0]      mag_ext;

	// Divider
	logic              div_start;
	logic              div_busy;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_NW-1:0] div_quot;
	logic [DIV_NW-1:0] pmin_num;
	logic [DIV_DW-1:0] div_den;

	// Output
	logic                    out_valid_q;
	logic signed [OFS_W-1:0] offset_q;
	logic [FRAC_W-1:0]       frac_q;
	logic                    emit_fire;
	logic                    in_fire;

	uword_t  uw;
	uflags_t flags;

	coo_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uw     (uw)
	);

	coo_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// Write configuration registers; ignore unknown indexes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_base_q <= '0;
			per_base_q <= '0;
			loop_q     <= BASE_W'(LOOP_RESET);
			amp_knob_q <= 1'b0;
			per_knob_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_AMP_BASE: amp_base_q <= cfg_data;
				REG_PER_BASE: per_base_q <= cfg_data;
				REG_LOOP:     loop_q     <= cfg_data;
				REG_AMP_KNOB: amp_knob_q <= cfg_data[0];
				REG_PER_KNOB: per_knob_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Take a word only on the fetch step
	assign in_ready = (uw.op == U_FETCH);
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q   <= active;
			now_q   <= now_ms;
			apct_q  <= amplitude_pct;
			ppct_q  <= period_pct;
			climb_q <= max_climb_cms;
			desc_q  <= max_descent_cms;
		end
	end

	// Status for the sequencer
	assign emit_fire = (uw.op == U_EMIT) && !flags.out_full;

	always_comb begin
		flags.no_in    = !in_valid;
		flags.drop     = !act_q || (!amp_knob_q && !per_knob_q);
		flags.spd_zero = (spd_q == '0);
		flags.no_adv   = (per_q == '0) || stop_q;
		flags.div_busy = div_busy;
		flags.out_full = out_valid_q && !out_ready;
	end

	// Knob scale: without a knob multiply by 100 so the divide gives the base back
	assign pct_a  = amp_knob_q ? sat_pct(apct_q) : PCT_W'(PCT_FULL);
	assign pct_p  = per_knob_q ? sat_pct(ppct_q) : PCT_W'(PCT_FULL);
	assign gap_ms = now_q - last_q;

	// Pick multiplier operands for the current step
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b0;
		case (uw.op)
			U_MUL_AMP: begin
				mul_a  = MUL_A_W'(amp_base_q);
				mul_b  = MUL_B_W'(pct_a);
				mul_en = 1'b1;
			end
			U_RECIP: begin
				mul_a  = MUL_A_W'(prod_q[RECIP_IN_W-1:0]);
				mul_b  = RECIP_100;
				mul_en = 1'b1;
			end
			U_AMP_MUL_PER: begin
				mul_a  = MUL_A_W'(per_base_q);
				mul_b  = MUL_B_W'(pct_p);
				mul_en = 1'b1;
			end
			U_PER_MUL_200: begin
				mul_a  = MUL_A_W'(amp_q);
				mul_b  = MUL_B_W'(PMIN_SCALE);
				mul_en = 1'b1;
			end
			U_MUL_1000: begin
				mul_a  = MUL_A_W'(per_q);
				mul_b  = MUL_B_W'(MS_TO_US);
				mul_en = 1'b1;
			end
			U_MUL_MAG: begin
				mul_a  = MUL_A_W'(coef_q);
				mul_b  = MUL_B_W'(amp_q);
				mul_en = 1'b1;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Divider operands: ceil(200*amp/speed), then (loop << PHASE_BITS) / (period*1000)
	assign pmin_num  = DIV_NW'(prod_q[PMIN_W-1:0]) + DIV_NW'(spd_q) - DIV_NW'(1);
	assign div_start = ((uw.op == U_DIV_PMIN) && !flags.spd_zero) || (uw.op == U_DIV_STEP);
	assign div_num   = (uw.op == U_DIV_STEP) ? (DIV_NW'(loop_q) << PHASE_BITS) : pmin_num;
	assign div_den   = (uw.op == U_DIV_STEP) ? prod_q[DIV_DW-1:0] : DIV_DW'(spd_q);

	// Phase and tick time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			last_q  <= '0;
		end else begin
			case (uw.op)
				U_GAP: begin
					last_q <= now_q;
					if (gap_ms > TIME_W'(GAP_LIMIT_MS))
						phase_q <= '0;
				end
				U_ADD_STEP: begin
					if (!div_busy)
						phase_q <= phase_q + div_quot[PHASE_BITS-1:0];
				end
				U_AMP_ZERO: begin
					if (amp_q == '0)
						phase_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul_p;
		case (uw.op)
			U_GAP: begin
				spd_q  <= (climb_q < desc_q) ? climb_q : desc_q;
				stop_q <= per_knob_q && (pct_p == PCT_W'(PCT_FULL));
			end
			U_AMP_MUL_PER: amp_q <= prod_q[RECIP_SHIFT +: AMP_W];
			U_PER_MUL_200: per_q <= PER_W'(prod_q[RECIP_SHIFT +: BASE_W]);
			U_MAX_PMIN: begin
				if (!div_busy && (PER_W'(div_quot) > per_q))
					per_q <= PER_W'(div_quot);
			end
			default: ;
		endcase
	end

	// Cosine ROM, read every cycle at the current phase
	assign idx_prod = IDXP_W'(phase_q) * IDXP_W'(COS_TABLE_ENTRIES);
	assign cidx     = idx_prod[PHASE_BITS +: CIDX_W];

	always_ff @(posedge clk) begin
		coef_q <= COEF_ROM[cidx];
	end

	// Round the magnitude and negate
	assign mag_sum = MAG_SUM_W'(prod_q[COEF_W+AMP_W-1:0]) + MAG_SUM_W'(MAG_ROUND);
	assign mag_ext = OFS_W'(mag_sum[MAG_SHIFT +: AMP_W]);

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			offset_q <= '0 - mag_ext;
			frac_q   <= FRAC_W'(phase_q);
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign offset_mm  = offset_q;
	assign phase_frac = frac_q;

	a_offset_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (offset_mm[OFS_W-1] || (offset_mm == '0)))
		else $error("positive offset on output");

	a_amp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && (amp_q == '0)) |=> ((offset_mm == '0) && (phase_frac == '0)))
		else $error("zero amplitude must give zero offset and phase");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_fetch_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_busy)
		else $error("divider still busy at fetch");

endmodule

FILE: rtl/core/coo_div.sv
module coo_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [coo_pkg::DIV_NW-1:0]  num,
	input  logic [coo_pkg::DIV_DW-1:0]  den,
	output logic                        busy,
	output logic [coo_pkg::DIV_NW-1:0]  quot
);
	import coo_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DW-1:0]    rem_q;
	logic [DIV_DW-1:0]    den_q;
	logic [DIV_NW-1:0]    qn_q;
	logic [DIV_DW:0]      try_a;
	logic [DIV_DW:0]      try_b;
	logic [DIV_DW-1:0]    rem_mid;
	logic [DIV_DW-1:0]    rem_next;
	logic                 ge_a;
	logic                 ge_b;

	// Two restoring steps: shift in the next numerator bit, subtract if it fits
	always_comb begin
		try_a    = {rem_q, qn_q[DIV_NW-1]};
		ge_a     = try_a >= {1'b0, den_q};
		rem_mid  = ge_a ? DIV_DW'(try_a - {1'b0, den_q}) : try_a[DIV_DW-1:0];
		try_b    = {rem_mid, qn_q[DIV_NW-2]};
		ge_b     = try_b >= {1'b0, den_q};
		rem_next = ge_b ? DIV_DW'(try_b - {1'b0, den_q}) : try_b[DIV_DW-1:0];
	end

	// Count iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_ITER - 1);
		end else if (busy_q) begin
			busy_q <= (cnt_q != '0);
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	// Load operands, then shift quotient bits in as numerator bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			qn_q  <= num;
		end else if (busy_q) begin
			rem_q <= rem_next;
			qn_q  <= {qn_q[DIV_NW-3:0], ge_a, ge_b};
		end
	end

	assign busy = busy_q;
	assign quot = qn_q;

endmodule

FILE: rtl/core/coo_seq.sv
module coo_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  coo_pkg::uflags_t flags,
	output coo_pkg::uword_t  uw
);
	import coo_pkg::*;

	// Program step labels
	localparam logic [UC_PC_W-1:0] S_FETCH    = UC_PC_W'(0);
	localparam logic [UC_PC_W-1:0] S_CHECK    = UC_PC_W'(1);
	localparam logic [UC_PC_W-1:0] S_GAP      = UC_PC_W'(2);
	localparam logic [UC_PC_W-1:0] S_MUL_AMP  = UC_PC_W'(3);
	localparam logic [UC_PC_W-1:0] S_RECIP_A  = UC_PC_W'(4);
	localparam logic [UC_PC_W-1:0] S_MUL_PER  = UC_PC_W'(5);
	localparam logic [UC_PC_W-1:0] S_RECIP_P  = UC_PC_W'(6);
	localparam logic [UC_PC_W-1:0] S_MUL_200  = UC_PC_W'(7);
	localparam logic [UC_PC_W-1:0] S_DIV_PMIN = UC_PC_W'(8);
	localparam logic [UC_PC_W-1:0] S_MAX_PMIN = UC_PC_W'(9);
	localparam logic [UC_PC_W-1:0] S_MUL_1000 = UC_PC_W'(10);
	localparam logic [UC_PC_W-1:0] S_DIV_STEP = UC_PC_W'(11);
	localparam logic [UC_PC_W-1:0] S_ADD_STEP = UC_PC_W'(12);
	localparam logic [UC_PC_W-1:0] S_AMP_ZERO = UC_PC_W'(13);
	localparam logic [UC_PC_W-1:0] S_ROM_READ = UC_PC_W'(14);
	localparam logic [UC_PC_W-1:0] S_MUL_MAG  = UC_PC_W'(15);
	localparam logic [UC_PC_W-1:0] S_EMIT     = UC_PC_W'(16);
	localparam logic [UC_PC_W-1:0] S_RETURN   = UC_PC_W'(17);

	logic [UC_PC_W-1:0] pc_q;
	logic [UC_PC_W-1:0] pc_next;
	logic               taken;

	// Control store
	always_comb begin
		case (pc_q)
			S_FETCH:    uw = '{op: U_FETCH,       cond: C_NO_IN,    target: S_FETCH};
			S_CHECK:    uw = '{op: U_NOP,         cond: C_DROP,     target: S_FETCH};
			S_GAP:      uw = '{op: U_GAP,         cond: C_NEVER,    target: S_FETCH};
			S_MUL_AMP:  uw = '{op: U_MUL_AMP,     cond: C_NEVER,    target: S_FETCH};
			S_RECIP_A:  uw = '{op: U_RECIP,       cond: C_NEVER,    target: S_FETCH};
			S_MUL_PER:  uw = '{op: U_AMP_MUL_PER, cond: C_NEVER,    target: S_FETCH};
			S_RECIP_P:  uw = '{op: U_RECIP,       cond: C_NEVER,    target: S_FETCH};
			S_MUL_200:  uw = '{op: U_PER_MUL_200, cond: C_NEVER,    target: S_FETCH};
			S_DIV_PMIN: uw = '{op: U_DIV_PMIN,    cond: C_SPD_ZERO, target: S_MUL_1000};
			S_MAX_PMIN: uw = '{op: U_MAX_PMIN,    cond: C_DIV_BUSY, target: S_MAX_PMIN};
			S_MUL_1000: uw = '{op: U_MUL_1000,    cond: C_NO_ADV,   target: S_AMP_ZERO};
			S_DIV_STEP: uw = '{op: U_DIV_STEP,    cond: C_NEVER,    target: S_FETCH};
			S_ADD_STEP: uw = '{op: U_ADD_STEP,    cond: C_DIV_BUSY, target: S_ADD_STEP};
			S_AMP_ZERO: uw = '{op: U_AMP_ZERO,    cond: C_NEVER,    target: S_FETCH};
			S_ROM_READ: uw = '{op: U_NOP,         cond: C_NEVER,    target: S_FETCH};
			S_MUL_MAG:  uw = '{op: U_MUL_MAG,     cond: C_NEVER,    target: S_FETCH};
			S_EMIT:     uw = '{op: U_EMIT,        cond: C_OUT_FULL, target: S_EMIT};
			S_RETURN:   uw = '{op: U_NOP,         cond: C_ALWAYS,   target: S_FETCH};
			default:    uw = '{op: U_NOP,         cond: C_ALWAYS,   target: S_FETCH};
		endcase
	end

	// Select the jump condition and the next step
	always_comb begin
		case (uw.cond)
			C_NEVER:    taken = 1'b0;
			C_ALWAYS:   taken = 1'b1;
			C_NO_IN:    taken = flags.no_in;
			C_DROP:     taken = flags.drop;
			C_SPD_ZERO: taken = flags.spd_zero;
			C_NO_ADV:   taken = flags.no_adv;
			C_DIV_BUSY: taken = flags.div_busy;
			C_OUT_FULL: taken = flags.out_full;
			default:    taken = 1'b0;
		endcase
		pc_next = taken ? uw.target : pc_q + 1'b1;
	end

	// Advance the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_FETCH;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule
